// File: hdl/dacs_pkg.sv
// Shared constants, types and the full-scale table of the decimated ADC code scaler.
package dacs_pkg;

  localparam int FRAC   = 20;
  localparam int CODE_W = 24;
  localparam int FS_W   = 24;
  localparam int VAL_W  = 23;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 8;

  // Quotient of code * 2^FRAC / full stays below 2^(FRAC+1).
  localparam int QW   = FRAC + 1;
  localparam int NDIV = QW;

  // The floor division by 35 runs on x = 48*q + 11*2^FRAC, which is never negative.
  localparam int XW = FRAC + 7;
  localparam int MW = FRAC + 8;
  localparam int PW = XW + MW;
  localparam int SH = XW + 6;
  localparam int DW = PW - SH;

  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'd34) / 64'd35);
  localparam logic [XW-1:0] X_OFS = XW'(64'd11 << FRAC);
  localparam logic [DW-1:0] D_OFS = DW'(64'd1 << FRAC);

  localparam longint OUT_MAX = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
  localparam longint OUT_MIN = -(64'sd1 <<< (VAL_W - 1));

  typedef enum logic [CFG_AW-1:0] {
    REG_SHARED_RATE = 3'd0,
    REG_RATE_CH0    = 3'd1,
    REG_RATE_CH1    = 3'd2,
    REG_RATE_CH2    = 3'd3,
    REG_CH_ENABLE   = 3'd4
  } reg_idx_t;

  localparam logic [3:0] R2_DEC4 = 4'h1;
  localparam logic [3:0] R2_DEC5 = 4'h2;
  localparam logic [3:0] R2_DEC6 = 4'h4;
  localparam logic [3:0] R2_DEC8 = 4'h8;

  localparam logic [7:0] R3_DEC6  = 8'h02;
  localparam logic [7:0] R3_DEC8  = 8'h04;
  localparam logic [7:0] R3_DEC12 = 8'h08;
  localparam logic [7:0] R3_DEC16 = 8'h10;

  localparam logic [FS_W-1:0] FS_FAST_A = 24'h008000;
  localparam logic [FS_W-1:0] FS_FAST_B = 24'h00C350;
  localparam logic [FS_W-1:0] FS_FAST_C = 24'h00F300;
  localparam logic [FS_W-1:0] FS_PREC_A = 24'h800000;
  localparam logic [FS_W-1:0] FS_PREC_B = 24'hC35000;
  localparam logic [FS_W-1:0] FS_PREC_C = 24'hF30000;
  localparam logic [FS_W-1:0] FS_PREC_D = 24'hB964F0;
  localparam logic [FS_W-1:0] FS_PREC_E = 24'hE6A900;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [FS_W-1:0]   full;
    logic              dis;
  } smp_t;

  typedef struct packed {
    logic [QW-1:0]   quo;
    logic [FS_W-1:0] full;
    logic            dis;
  } quo_t;

  function automatic logic [FS_W-1:0] full_scale(input logic fast, input logic [3:0] r2,
                                                  input logic [7:0] r3);
    logic            r3_lo;
    logic            r3_hi;
    logic [FS_W-1:0] fmax;
    logic [FS_W-1:0] pmax;
    r3_lo = (r3 == R3_DEC6) || (r3 == R3_DEC12);
    r3_hi = (r3 == R3_DEC8) || (r3 == R3_DEC16);
    fmax  = FS_FAST_A;
    pmax  = FS_PREC_A;
    case (r2)
      R2_DEC4, R2_DEC8: begin
        fmax = FS_FAST_A;
        pmax = r3_lo ? FS_PREC_C : FS_PREC_A;
      end
      R2_DEC5: begin
        fmax = FS_FAST_B;
        pmax = r3_hi ? FS_PREC_D : FS_PREC_B;
      end
      R2_DEC6: begin
        fmax = FS_FAST_C;
        pmax = r3_hi ? FS_PREC_E : FS_PREC_C;
      end
      default: begin
        fmax = FS_FAST_A;
        pmax = FS_PREC_A;
      end
    endcase
    return fast ? fmax : pmax;
  endfunction

endpackage

// File: hdl/dacs_front.sv
// Configuration registers, full-scale lookup and the input register stage.
module dacs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dacs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [dacs_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        in_vld,
  output logic                        in_rdy,
  input  logic                        cmd,
  input  logic [1:0]                  chan,
  input  logic [dacs_pkg::CODE_W-1:0] code_in,
  output logic                        out_vld,
  input  logic                        out_rdy,
  output dacs_pkg::smp_t              out
);
  import dacs_pkg::*;

  logic [3:0] shared_rate;
  logic [7:0] rate_ch0;
  logic [7:0] rate_ch1;
  logic [7:0] rate_ch2;
  logic [2:0] en_mask;

  logic              vld;
  smp_t              stage;
  logic [7:0]        r3;
  logic              enabled;
  logic [CODE_W-1:0] code_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      shared_rate <= R2_DEC8;
      rate_ch0    <= 8'h80;
      rate_ch1    <= 8'h80;
      rate_ch2    <= 8'h80;
      en_mask     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHARED_RATE: shared_rate <= cfg_wdata[3:0];
        REG_RATE_CH0:    rate_ch0    <= cfg_wdata;
        REG_RATE_CH1:    rate_ch1    <= cfg_wdata;
        REG_RATE_CH2:    rate_ch2    <= cfg_wdata;
        REG_CH_ENABLE:   en_mask     <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Channel three has no rate code of its own and always counts as disabled.
  always_comb begin
    case (chan)
      2'd0: begin
        r3      = rate_ch0;
        enabled = en_mask[0];
      end
      2'd1: begin
        r3      = rate_ch1;
        enabled = en_mask[1];
      end
      2'd2: begin
        r3      = rate_ch2;
        enabled = en_mask[2];
      end
      default: begin
        r3      = '0;
        enabled = 1'b0;
      end
    endcase
  end

  assign code_m = cmd ? {{(CODE_W - 16){1'b0}}, code_in[15:0]} : code_in;

  assign in_rdy = !vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_rdy) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      stage.code <= code_m;
      stage.full <= full_scale(cmd, shared_rate, r3);
      stage.dis  <= !enabled;
    end
  end

  assign out_vld = vld;
  assign out     = stage;

endmodule

// File: hdl/dacs_div.sv
// Pipelined restoring divider: one quotient bit of code * 2^FRAC / full per stage.
module dacs_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  output logic           in_rdy,
  input  dacs_pkg::smp_t in,
  output logic           out_vld,
  input  logic           out_rdy,
  output dacs_pkg::quo_t out
);
  import dacs_pkg::*;

  logic            vld  [NDIV];
  logic            rdy  [NDIV];
  logic [FS_W-1:0] rem  [NDIV];
  logic [QW-1:0]   quo  [NDIV];
  logic [FS_W-1:0] full [NDIV];
  logic            dis  [NDIV];

  for (genvar i = 0; i < NDIV; i++) begin : g_stage
    logic [FS_W:0]   trial;
    logic            qbit;
    logic            pv;
    logic [QW-1:0]   pq;
    logic [FS_W-1:0] pfull;
    logic            pdis;
    logic            nrdy;
    logic [FS_W-1:0] rem_next;

    // The code's upper bits are always below full, so the first trial is the code itself.
    if (i == 0) begin : g_first
      assign trial = {1'b0, in.code};
      assign pv    = in_vld;
      assign pq    = '0;
      assign pfull = in.full;
      assign pdis  = in.dis;
    end else begin : g_next
      assign trial = {rem[i-1], 1'b0};
      assign pv    = vld[i-1];
      assign pq    = quo[i-1];
      assign pfull = full[i-1];
      assign pdis  = dis[i-1];
    end

    if (i == NDIV - 1) begin : g_last
      assign nrdy = out_rdy;
    end else begin : g_mid
      assign nrdy = rdy[i+1];
    end

    assign qbit     = trial >= {1'b0, pfull};
    assign rem_next = qbit ? FS_W'(trial - {1'b0, pfull}) : FS_W'(trial);
    assign rdy[i]   = !vld[i] || nrdy;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && pv) begin
        rem[i]  <= rem_next;
        quo[i]  <= {pq[QW-2:0], qbit};
        full[i] <= pfull;
        dis[i]  <= pdis;
      end
    end
  end

  assign in_rdy   = rdy[0];
  assign out_vld  = vld[NDIV-1];
  assign out.quo  = quo[NDIV-1];
  assign out.full = full[NDIV-1];
  assign out.dis  = dis[NDIV-1];

endmodule

// File: hdl/dacs_post.sv
// Three stages: offset and scale by 48, multiply by the reciprocal of 35, shift and saturate.
module dacs_post (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_vld,
  output logic                              in_rdy,
  input  dacs_pkg::quo_t                    in,
  output logic                              out_vld,
  input  logic                              out_rdy,
  output logic signed [dacs_pkg::VAL_W-1:0] scaled,
  output logic [dacs_pkg::FS_W-1:0]         full_out,
  output logic                              dis_out
);
  import dacs_pkg::*;

  logic            vld_a, vld_b, vld_c;
  logic            rdy_a, rdy_b, rdy_c;
  logic [XW-1:0]   x_a;
  logic [PW-1:0]   prod_b;
  logic [FS_W-1:0] full_a, full_b;
  logic            dis_a, dis_b;

  logic [XW-1:0]        x_next;
  logic [PW-1:0]        prod_next;
  logic [DW-1:0]        d;
  logic signed [DW:0]   v;
  logic [VAL_W-1:0]     sat;

  assign rdy_c  = !vld_c || out_rdy;
  assign rdy_b  = !vld_b || rdy_c;
  assign rdy_a  = !vld_a || rdy_b;
  assign in_rdy = rdy_a;

  // 48*(q - 2^(FRAC-1)) + 35*2^FRAC keeps the dividend positive for the floor division.
  assign x_next    = (XW'(in.quo) << 5) + (XW'(in.quo) << 4) + X_OFS;
  assign prod_next = PW'(x_a) * PW'(RECIP);
  assign d         = prod_b[PW-1:SH];
  assign v         = $signed({1'b0, d}) - $signed({1'b0, D_OFS});

  always_comb begin
    if (longint'(v) > OUT_MAX) begin
      sat = VAL_W'(OUT_MAX);
    end else if (longint'(v) < OUT_MIN) begin
      sat = VAL_W'(OUT_MIN);
    end else begin
      sat = VAL_W'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a <= in_vld;
      end
      if (rdy_b) begin
        vld_b <= vld_a;
      end
      if (rdy_c) begin
        vld_c <= vld_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_vld) begin
      x_a    <= x_next;
      full_a <= in.full;
      dis_a  <= in.dis;
    end
    if (rdy_b && vld_a) begin
      prod_b <= prod_next;
      full_b <= full_a;
      dis_b  <= dis_a;
    end
    if (rdy_c && vld_b) begin
      scaled   <= dis_b ? '0 : $signed(sat);
      full_out <= full_b;
      dis_out  <= dis_b;
    end
  end

  assign out_vld = vld_c;

endmodule

// File: hdl/decimated_adc_code_scaler_top.sv
// Top level of the decimated ADC code scaler.
//
// Input stream s_*: one beat per assembled ADC code. s_tdata carries the 24-bit
// code, s_tuser the sample kind (precise or fast) and the channel number.
// Output stream m_*: one beat per input beat, in order, with the signed Q3.20
// voltage, the full-scale code that was used and a flag for a disabled channel.
// The configuration port writes the rate codes and the channel enable mask; the user
// must write it only while no beat is in flight, which the block does not enforce.
// The path has 25 register stages: one register stage for the table
// lookup, 21 divider stages (one quotient bit each) and three stages for the
// scale by 48/35 and saturation.
// Throughput: one beat per cycle while m_tready is high. Every stage holds its own valid bit and moves
// when the stage after it is empty or moving, so bubbles close up while the
// receiver stalls and a new beat is taken as long as any stage is free.
// Reset clears all valid bits and loads the register reset values; nothing is
// lost or repeated across a stall.
module decimated_adc_code_scaler_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dacs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [dacs_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,  // [23:0] sample_code
  input  logic [2:0]                  s_tuser,  // [0] command, [2:1] channel
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [47:0]                 m_tdata,  // [22:0] scaled_value, [46:23] full_scale
  output logic                        m_tuser   // [0] was_disabled
);
  import dacs_pkg::*;

  logic              f_vld, f_rdy;
  smp_t              f_data;
  logic              d_vld, d_rdy;
  quo_t              d_data;
  logic [VAL_W-1:0]  scaled;
  logic [FS_W-1:0]   full;
  logic              dis;

  dacs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_vld    (s_tvalid),
    .in_rdy    (s_tready),
    .cmd       (s_tuser[0]),
    .chan      (s_tuser[2:1]),
    .code_in   (s_tdata),
    .out_vld   (f_vld),
    .out_rdy   (f_rdy),
    .out       (f_data)
  );

  dacs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (f_vld),
    .in_rdy  (f_rdy),
    .in      (f_data),
    .out_vld (d_vld),
    .out_rdy (d_rdy),
    .out     (d_data)
  );

  dacs_post u_post (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (d_vld),
    .in_rdy   (d_rdy),
    .in       (d_data),
    .out_vld  (m_tvalid),
    .out_rdy  (m_tready),
    .scaled   (scaled),
    .full_out (full),
    .dis_out  (dis)
  );

  assign m_tdata = {1'b0, full, scaled};
  assign m_tuser = dis;

endmodule

// File: hdl/dacs_checker.sv
// Port-level checker for the decimated ADC code scaler, bound to the top level.
module dacs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // Input is refused only when every stage is full and the receiver is stalling.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input refused while the pipeline could move");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output beat changed");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[22:0] == 23'd0))
    else $error("disabled channel gave a nonzero value");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[46:23] == 24'h008000 || m_tdata[46:23] == 24'h00C350 ||
                  m_tdata[46:23] == 24'h00F300 || m_tdata[46:23] == 24'h800000 ||
                  m_tdata[46:23] == 24'hC35000 || m_tdata[46:23] == 24'hF30000 ||
                  m_tdata[46:23] == 24'hB964F0 || m_tdata[46:23] == 24'hE6A900))
    else $error("full-scale code outside the table");

  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind decimated_adc_code_scaler_top dacs_checker u_dacs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
